// File: design/hlkp_pkg.sv
// ----------------------------------------------------------------------------
// hlkp_pkg
// Shared types, keyword table and character codes for the header line
// keyword parser.
// ----------------------------------------------------------------------------
package hlkp_pkg;

  localparam int KW_COUNT   = 9;
  localparam int KW_MAX_LEN = 16;

  typedef logic [3:0] name_pos_t;
  typedef logic [2:0] tag_t;
  typedef logic [KW_COUNT-1:0] kw_mask_t;

  localparam name_pos_t POS_MAX = 4'd15;

  localparam tag_t TAG_NONE       = 3'd0;
  localparam tag_t TAG_PROTOCOL   = 3'd1;
  localparam tag_t TAG_DOMAIN     = 3'd2;
  localparam tag_t TAG_CONTENT    = 3'd3;
  localparam tag_t TAG_APP_NAME   = 3'd4;
  localparam tag_t TAG_SCHEMA     = 3'd5;
  localparam tag_t TAG_SENDER_ID  = 3'd6;
  localparam tag_t TAG_START_TIME = 3'd7;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_COLON = 2'd1,
    ST_UNKNOWN  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_NAME       = 4'b0001,
    PH_SEEK_COLON = 4'b0010,
    PH_SKIP_WS    = 4'b0100,
    PH_VALUE      = 4'b1000
  } phase_t;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // keyword text, right-justified in a 16 byte field
  localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
    "protocol", "domain", "experiment-id", "content", "app-name",
    "schema", "sender-id", "start-time", {"start", "_", "time"}
  };

  localparam name_pos_t KW_LEN [KW_COUNT] = '{
    4'd8, 4'd6, 4'd13, 4'd7, 4'd8, 4'd6, 4'd9, 4'd10, 4'd10
  };

  localparam tag_t KW_TAG [KW_COUNT] = '{
    TAG_PROTOCOL, TAG_DOMAIN, TAG_DOMAIN, TAG_CONTENT, TAG_APP_NAME,
    TAG_SCHEMA, TAG_SENDER_ID, TAG_START_TIME, TAG_START_TIME
  };

  typedef struct packed {
    logic       has_byte;
    logic [7:0] value_byte;
    tag_t       tag;
    status_t    status;
    logic       last;
  } result_t;

  // character of keyword kw at position pos, valid for pos below its length
  function automatic logic [7:0] kw_char(input int kw, input name_pos_t pos);
    name_pos_t  off;
    logic [6:0] bit_idx;
    off     = KW_LEN[kw] - 4'd1 - pos;
    bit_idx = {off, 3'b000};
    return KW_TEXT[kw][bit_idx +: 8];
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

endpackage

// File: design/hlkp_if.sv
// ----------------------------------------------------------------------------
// hlkp_if
// Valid/ready channels of the header line keyword parser: line characters in,
// tagged value characters and line status out.
// ----------------------------------------------------------------------------
interface hlkp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       line_end;

  modport source (output valid, line_byte, line_end, input ready);
  modport sink   (input valid, line_byte, line_end, output ready);
endinterface

interface hlkp_result_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] value_byte;
  logic [2:0] tag;
  logic [1:0] status;
  logic       last;

  modport source (output valid, has_byte, value_byte, tag, status, last, input ready);
  modport sink   (input valid, has_byte, value_byte, tag, status, last, output ready);
endinterface

// File: design/header_line_keyword_parser.sv
// ----------------------------------------------------------------------------
// header_line_keyword_parser
// Parses one "name: value" header line a byte at a time, matches the name
// against the keyword set and emits tagged value bytes and a final status.
// ----------------------------------------------------------------------------
//   port      direction  payload
//   chars     sink       line_byte, line_end
//   results   source     has_byte, value_byte, tag, status, last
//
// one character per cycle while the skid register is empty; each result is
// driven from a register. the keyword mask is updated for all nine keywords
// in parallel, so nothing loops per character. an output register plus a skid
// register keep chars ready while one result waits. rst is synchronous and
// returns the parser to the start of a line with both output stages empty.
// ----------------------------------------------------------------------------
module header_line_keyword_parser
  import hlkp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  hlkp_char_if.sink         chars,
  hlkp_result_if.source     results
);

  phase_t    phase, phase_next;
  name_pos_t name_position, name_position_next;
  kw_mask_t  keyword_match_mask, keyword_match_mask_next;
  tag_t      found_tag, found_tag_next;
  logic      value_started, value_started_next;

  logic      out_valid;
  result_t   out_data;
  logic      skid_valid;
  result_t   skid_data;

  logic      accept;
  logic      emit;
  logic      produce;
  result_t   new_data;
  kw_mask_t  keep;
  tag_t      resolved_tag;
  logic      ws, colon;

  assign accept = chars.valid && chars.ready;
  assign ws     = is_ws(chars.line_byte);
  assign colon  = (chars.line_byte == CH_COLON);

  always_comb begin
    for (int i = 0; i < KW_COUNT; i++) begin
      keep[i] = (name_position < KW_LEN[i]) &&
                (kw_char(i, name_position) == chars.line_byte);
    end
  end

  always_comb begin
    resolved_tag = TAG_NONE;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if (keyword_match_mask[i] && (KW_LEN[i] == name_position)) begin
        resolved_tag = KW_TAG[i];
      end
    end
  end

  always_comb begin
    phase_next              = phase;
    name_position_next      = name_position;
    keyword_match_mask_next = keyword_match_mask;
    found_tag_next          = found_tag;
    value_started_next      = value_started;
    emit                    = 1'b0;
    case (phase)
      PH_NAME: begin
        if (colon) begin
          found_tag_next = resolved_tag;
          phase_next     = PH_SKIP_WS;
        end else if (ws) begin
          found_tag_next = resolved_tag;
          phase_next     = PH_SEEK_COLON;
        end else begin
          keyword_match_mask_next = keyword_match_mask & keep;
          if (name_position != POS_MAX) begin
            name_position_next = name_position + 4'd1;
          end
        end
      end
      PH_SEEK_COLON: begin
        if (colon) begin
          phase_next = PH_SKIP_WS;
        end
      end
      PH_SKIP_WS: begin
        if (!ws) begin
          phase_next         = PH_VALUE;
          value_started_next = 1'b1;
          emit               = (found_tag != TAG_NONE);
        end
      end
      PH_VALUE: begin
        emit = (found_tag != TAG_NONE);
      end
      default: begin
        phase_next = PH_NAME;
      end
    endcase
  end

  always_comb begin
    new_data.has_byte   = emit;
    new_data.value_byte = emit ? chars.line_byte : 8'd0;
    new_data.tag        = found_tag_next;
    new_data.status     = ST_OK;
    new_data.last       = chars.line_end;
    if (chars.line_end) begin
      if (phase_next == PH_NAME || phase_next == PH_SEEK_COLON) begin
        new_data.status = ST_NO_COLON;
        new_data.tag    = TAG_NONE;
      end else if (found_tag_next == TAG_NONE) begin
        new_data.status = ST_UNKNOWN;
        new_data.tag    = TAG_NONE;
      end else if (!value_started_next) begin
        new_data.status = ST_EMPTY;
      end
    end
  end

  assign produce = accept && (emit || chars.line_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_NAME;
      name_position      <= '0;
      keyword_match_mask <= '1;
      found_tag          <= TAG_NONE;
      value_started      <= 1'b0;
    end else if (accept) begin
      if (chars.line_end) begin
        phase              <= PH_NAME;
        name_position      <= '0;
        keyword_match_mask <= '1;
        found_tag          <= TAG_NONE;
        value_started      <= 1'b0;
      end else begin
        phase              <= phase_next;
        name_position      <= name_position_next;
        keyword_match_mask <= keyword_match_mask_next;
        found_tag          <= found_tag_next;
        value_started      <= value_started_next;
      end
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (results.ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (results.ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : new_data;
    end else if (produce) begin
      skid_data <= new_data;
    end
  end

  assign chars.ready        = !skid_valid;
  assign results.valid      = out_valid;
  assign results.has_byte   = out_data.has_byte;
  assign results.value_byte = out_data.value_byte;
  assign results.tag        = out_data.tag;
  assign results.status     = out_data.status;
  assign results.last       = out_data.last;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a transfer while output register is empty");

  a_line_end_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && chars.line_end) |=> (phase == PH_NAME && name_position == '0 &&
                                    keyword_match_mask == '1 && !value_started))
    else $error("parser did not restart after end of line");

  a_status_only_last: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.last) |-> (results.status == ST_OK))
    else $error("status set on a result that is not the last of the line");

  a_byte_has_tag: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.has_byte) |-> (results.tag != TAG_NONE))
    else $error("value byte emitted without a tag");

  a_value_needs_start: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_VALUE) |-> value_started)
    else $error("value phase entered without value start");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the header line keyword parser. Lines of characters are
// driven into the parser: a few hand-picked lines first, then random lines.
// Most random lines are well-formed headers. The rest are altered names,
// names that are too long, lines with no colon and plain noise. A line model
// in the testbench predicts every tagged value character and line status,
// and each result transfer is checked against it in order. Each phase of the
// run uses different stall rates on the input and output sides; the last has none.
// ----------------------------------------------------------------------------
module tb_top
  import hlkp_pkg::*;
;

  typedef struct {
    logic [7:0] b;
    logic       e;
  } line_char_t;

  logic clk;
  logic rst;

  hlkp_char_if   chars_if ();
  hlkp_result_if results_if ();

  header_line_keyword_parser dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if)
  );

  string kw_word [KW_COUNT] = '{
    "protocol", "domain", "experiment-id", "content", "app-name",
    "schema", "sender-id", "start-time", {"start", "_", "time"}
  };
  tag_t kw_code [KW_COUNT] = '{
    TAG_PROTOCOL, TAG_DOMAIN, TAG_DOMAIN, TAG_CONTENT, TAG_APP_NAME,
    TAG_SCHEMA, TAG_SENDER_ID, TAG_START_TIME, TAG_START_TIME
  };

  line_char_t line_chars_q [$];
  result_t    tagged_out_q [$];
  logic [7:0] line_buf [$];
  line_char_t next_char;

  int send_idle_pct;
  int recv_stall_pct;
  int items_made;
  int mismatch_count;
  logic char_taken;

  // line model state
  phase_t    name_phase;
  name_pos_t name_pos;
  kw_mask_t  name_match;
  tag_t      line_tag;
  logic      value_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic blank(input logic [7:0] b);
    case (b)
      CH_SPACE, CH_TAB, CH_CR, CH_LF: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic tag_t name_tag();
    for (int i = 0; i < KW_COUNT; i++) begin
      if (name_match[i] && kw_word[i].len() == int'(name_pos)) return kw_code[i];
    end
    return TAG_NONE;
  endfunction

  task automatic clear_line();
    name_phase = PH_NAME;
    name_pos   = '0;
    name_match = '1;
    line_tag   = TAG_NONE;
    value_seen = 1'b0;
  endtask

  task automatic parse_char(input logic [7:0] b, input logic e);
    logic    emit;
    result_t r;
    emit = 1'b0;
    case (name_phase)
      PH_NAME: begin
        if (b == CH_COLON) begin
          line_tag   = name_tag();
          name_phase = PH_SKIP_WS;
        end else if (blank(b)) begin
          line_tag   = name_tag();
          name_phase = PH_SEEK_COLON;
        end else begin
          for (int i = 0; i < KW_COUNT; i++) begin
            if (!(int'(name_pos) < kw_word[i].len() && kw_word[i][int'(name_pos)] == b))
              name_match[i] = 1'b0;
          end
          if (name_pos != POS_MAX) name_pos = name_pos + 4'd1;
        end
      end
      PH_SEEK_COLON: begin
        if (b == CH_COLON) name_phase = PH_SKIP_WS;
      end
      PH_SKIP_WS: begin
        if (!blank(b)) begin
          name_phase = PH_VALUE;
          value_seen = 1'b1;
          emit       = (line_tag != TAG_NONE);
        end
      end
      default: emit = (line_tag != TAG_NONE);
    endcase
    if (emit || e) begin
      r.has_byte   = emit;
      r.value_byte = emit ? b : 8'h00;
      r.tag        = line_tag;
      r.status     = ST_OK;
      r.last       = e;
      if (e) begin
        if (name_phase == PH_NAME || name_phase == PH_SEEK_COLON) begin
          r.status = ST_NO_COLON;
          r.tag    = TAG_NONE;
        end else if (line_tag == TAG_NONE) begin
          r.status = ST_UNKNOWN;
          r.tag    = TAG_NONE;
        end else if (!value_seen) begin
          r.status = ST_EMPTY;
        end
      end
      tagged_out_q.push_back(r);
    end
    if (e) clear_line();
  endtask

  // line building
  task automatic put(input logic [7:0] b);
    line_buf.push_back(b);
  endtask

  task automatic put_word(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  task automatic end_line();
    line_char_t c;
    for (int i = 0; i < line_buf.size(); i++) begin
      c.b = line_buf[i];
      c.e = (i == line_buf.size() - 1);
      line_chars_q.push_back(c);
    end
    items_made += line_buf.size();
    line_buf.delete();
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] name_char();
    logic [7:0] b;
    if ($urandom_range(0, 1)) return 8'h61 + 8'($urandom_range(0, 25));
    do b = 8'($urandom_range(0, 255)); while (blank(b) || b == CH_COLON);
    return b;
  endfunction

  function automatic logic [7:0] value_char();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 255));
      1: return blank_char();
      default: return 8'($urandom_range(8'h20, 8'h7E));
    endcase
  endfunction

  task automatic value_tail();
    if ($urandom_range(0, 1)) begin
      put(CH_COLON);
    end else begin
      repeat ($urandom_range(1, 2)) put(blank_char());
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) put(name_char());
      put(CH_COLON);
    end
    repeat ($urandom_range(0, 2)) put(blank_char());
    if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) put(value_char());
  endtask

  task automatic random_line();
    int kind;
    int k;
    int pos;
    kind = $urandom_range(0, 99);
    k    = $urandom_range(0, KW_COUNT - 1);
    if (kind < 70) begin
      put_word(kw_word[k]);
      value_tail();
    end else if (kind < 80) begin
      put_word(kw_word[k]);
      case ($urandom_range(0, 2))
        0: begin
          pos = $urandom_range(0, line_buf.size() - 1);
          line_buf[pos] = name_char();
        end
        1: void'(line_buf.pop_back());
        default: put(name_char());
      endcase
      value_tail();
    end else if (kind < 85) begin
      repeat ($urandom_range(16, 20)) put(name_char());
      value_tail();
    end else if (kind < 90) begin
      put_word(kw_word[k]);
      if ($urandom_range(0, 1)) begin
        put(blank_char());
        repeat ($urandom_range(0, 3)) put(name_char());
      end
    end else begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 4) == 0) put(CH_COLON);
        else put(8'($urandom_range(0, 255)));
      end
    end
    end_line();
  endtask

  task automatic drain();
    while (line_chars_q.size() != 0 || chars_if.valid || tagged_out_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int target);
    int start;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start = items_made;
    while (items_made - start < target) random_line();
    drain();
  endtask

  // transfer sampling, prediction and result check
  always @(posedge clk) begin
    result_t got;
    result_t want;
    char_taken = !rst && chars_if.valid && chars_if.ready;
    if (char_taken) parse_char(chars_if.line_byte, chars_if.line_end);
    if (!rst && results_if.valid && results_if.ready) begin
      got.has_byte   = results_if.has_byte;
      got.value_byte = results_if.value_byte;
      got.tag        = results_if.tag;
      got.status     = status_t'(results_if.status);
      got.last       = results_if.last;
      if (tagged_out_q.size() == 0) begin
        $display("%0t: unexpected result has_byte=%b byte=%h tag=%0d status=%0d last=%b",
                 $time, got.has_byte, got.value_byte, got.tag, got.status, got.last);
        mismatch_count++;
      end else begin
        want = tagged_out_q.pop_front();
        if (got.has_byte !== want.has_byte || got.value_byte !== want.value_byte ||
            got.tag !== want.tag || got.status !== want.status || got.last !== want.last) begin
          $display("%0t: mismatch expected has_byte=%b byte=%h tag=%0d status=%0d last=%b",
                   $time, want.has_byte, want.value_byte, want.tag, want.status, want.last);
          $display("%0t:          actual   has_byte=%b byte=%h tag=%0d status=%0d last=%b",
                   $time, got.has_byte, got.value_byte, got.tag, got.status, got.last);
          mismatch_count++;
        end
      end
    end
  end

  // character driver and result stalls
  always @(negedge clk) begin
    if (rst) begin
      chars_if.valid <= 1'b0;
    end else if (!chars_if.valid || char_taken) begin
      if (line_chars_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_char = line_chars_q.pop_front();
        chars_if.valid     <= 1'b1;
        chars_if.line_byte <= next_char.b;
        chars_if.line_end  <= next_char.e;
      end else begin
        chars_if.valid <= 1'b0;
      end
    end
    results_if.ready <= !rst && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    rst                = 1'b1;
    chars_if.valid     = 1'b0;
    chars_if.line_byte = 8'h00;
    chars_if.line_end  = 1'b0;
    results_if.ready   = 1'b0;
    char_taken         = 1'b0;
    send_idle_pct      = 10;
    recv_stall_pct     = 62;
    items_made         = 0;
    mismatch_count     = 0;
    clear_line();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty name, blank then end, colon last, skipped junk with zero and top bytes
    put(CH_COLON);
    end_line();
    put(CH_SPACE);
    end_line();
    put_word("x");
    end_line();
    put_word("schema:");
    end_line();
    put_word("domain x:");
    put(8'h00);
    put(8'hFF);
    end_line();

    run_phase(10, 62, 130);
    run_phase(62, 10, 130);
    run_phase(0, 0, 130);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
